>>> hw/rtl/dmhs_pkg.sv
package dmhs_pkg;

  localparam int KeyBits = 32;
  localparam int CfgBits = 9;

  localparam logic [2:0] REQ_ADD        = 3'd0;
  localparam logic [2:0] REQ_FIND       = 3'd1;
  localparam logic [2:0] REQ_REMOVE     = 3'd2;
  localparam logic [2:0] REQ_ITER_START = 3'd3;
  localparam logic [2:0] REQ_ITER_NEXT  = 3'd4;
  localparam logic [2:0] REQ_ITER_REM   = 3'd5;

  // register index, taken from paddr[2]
  localparam logic CFG_ACTIVE_SIZE = 1'b0;

  localparam logic [CfgBits-1:0] ActiveSizeRst = CfgBits'(256);

  typedef struct packed {
    logic [2:0]         req_type;
    logic [KeyBits-1:0] key;
  } hs_req_t;

  typedef struct packed {
    logic               found;
    logic [KeyBits-1:0] item_value;
    logic               iter_done;
  } hs_rsp_t;

endpackage

>>> hw/rtl/dmhs_ram.sv
module dmhs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dmhs_mod_unit.sv
module dmhs_mod_unit import dmhs_pkg::*; #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [KeyBits-1:0]               dividend_i,
  input  logic [$clog2(TABLE_SLOTS+1)-1:0] divisor_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]   rem_o
);

  localparam int PosW = $clog2(TABLE_SLOTS + 1);
  localparam int SlotW = $clog2(TABLE_SLOTS);
  localparam int CntW = $clog2(KeyBits);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyBits-1:0] dvd_q, dvd_d;
  logic [PosW-1:0]   dvs_q, dvs_d;
  logic [PosW-1:0]   rem_q, rem_d;
  logic [PosW:0]     shifted;
  logic [PosW:0]     diff;

  // one restoring step per cycle, msb first
  assign shifted = {rem_q, dvd_q[KeyBits-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (busy_q) begin
      dvd_d = {dvd_q[KeyBits-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[PosW-1:0];
      end else begin
        rem_d = shifted[PosW-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(KeyBits - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  // remainder is below the divisor, so it fits a slot index
  assign done_o = done_q;
  assign rem_o  = rem_q[SlotW-1:0];

endmodule

>>> hw/rtl/direct_mapped_hash_set.sv
// add, find and remove use the 32-step shared remainder unit and the output register; find
//   and remove also a registered table read; zero keys and other requests but iterator next
//   go straight to the output register; iterator next first clears a pending remove, then
//   reads and checks one slot after another until a stored key or the end of the table
// a new request is taken in the cycle after the previous result reaches the output register
// after reset the table is cleared one slot a cycle, every slot in turn, with in_stall_o high
module direct_mapped_hash_set import dmhs_pkg::*; #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hs_req_t       in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hs_rsp_t       out_rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int PosW = $clog2(TABLE_SLOTS + 1);
  localparam int SlotW = $clog2(TABLE_SLOTS);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_NEXT_CLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } state_e;

  state_e               state_q;
  logic [SlotW-1:0]     clr_addr_q;
  logic [2:0]           req_q;
  logic [KeyBits-1:0]   key_q;
  logic [SlotW-1:0]     slot_q;
  logic [PosW-1:0]      pos_q;
  logic [SlotW-1:0]     last_slot_q;
  logic                 pend_q;
  logic                 lvalid_q;
  logic [CfgBits-1:0]   active_size_q;
  hs_rsp_t              rsp_q;
  logic                 out_valid_q;
  hs_rsp_t              out_rsp_q;

  logic [31:0]          size_ext;
  logic [PosW-1:0]      eff_size;
  logic                 in_acc;
  logic                 cfg_wr;
  logic                 div_start;
  logic                 div_done;
  logic [SlotW-1:0]     div_rem;
  logic                 ram_we;
  logic [SlotW-1:0]     ram_waddr;
  logic [KeyBits-1:0]   ram_wdata;
  logic                 ram_re;
  logic [SlotW-1:0]     ram_raddr;
  logic [KeyBits-1:0]   ram_rdata;
  logic                 pos_in_range;
  logic                 hashed_req;

  assign size_ext = {{(32 - CfgBits){1'b0}}, active_size_q};

  // zero acts as one, anything above the table acts as the table size
  always_comb begin
    if (active_size_q == '0) begin
      eff_size = PosW'(1);
    end else if (size_ext > 32'(TABLE_SLOTS)) begin
      eff_size = PosW'(TABLE_SLOTS);
    end else begin
      eff_size = size_ext[PosW-1:0];
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && (state_q == ST_IDLE);
  assign pos_in_range = (pos_q < eff_size);
  assign hashed_req   = (in_req_i.req_type == REQ_ADD) || (in_req_i.req_type == REQ_FIND) ||
                        (in_req_i.req_type == REQ_REMOVE);
  assign div_start    = in_acc && hashed_req && (in_req_i.key != '0);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_ACTIVE_SIZE);
  assign prdata = (paddr[2] == CFG_ACTIVE_SIZE) ? size_ext : 32'd0;

  dmhs_mod_unit #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_req_i.key),
    .divisor_i  (eff_size),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  dmhs_ram #(
    .Width(KeyBits),
    .Depth(TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = slot_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_UPD: begin
        if (req_q == REQ_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = key_q;
        end else if ((req_q == REQ_REMOVE) && (ram_rdata == key_q)) begin
          ram_we = 1'b1;
        end
      end
      ST_NEXT_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = last_slot_q;
      end
      ST_SCAN_RD: begin
        ram_re    = pos_in_range;
        ram_raddr = pos_q[SlotW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      req_q         <= REQ_ADD;
      key_q         <= '0;
      slot_q        <= '0;
      pos_q         <= '0;
      last_slot_q   <= '0;
      pend_q        <= 1'b0;
      lvalid_q      <= 1'b0;
      active_size_q <= ActiveSizeRst;
      rsp_q         <= '0;
      out_valid_q   <= 1'b0;
      out_rsp_q     <= '0;
    end else begin
      if (cfg_wr) begin
        active_size_q <= pwdata[CfgBits-1:0];
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + SlotW'(1);
          if (clr_addr_q == SlotW'(TABLE_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_q <= in_req_i.req_type;
            key_q <= in_req_i.key;
            rsp_q <= '0;
            state_q <= ST_RESP;
            if (hashed_req) begin
              if (in_req_i.key != '0) begin
                state_q <= ST_DIV;
              end
            end else if (in_req_i.req_type == REQ_ITER_START) begin
              pos_q    <= '0;
              pend_q   <= 1'b0;
              lvalid_q <= 1'b0;
            end else if (in_req_i.req_type == REQ_ITER_NEXT) begin
              state_q <= pend_q ? ST_NEXT_CLR : ST_SCAN_RD;
            end else if (in_req_i.req_type == REQ_ITER_REM) begin
              if (lvalid_q) begin
                pend_q <= 1'b1;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            slot_q  <= div_rem;
            state_q <= (req_q == REQ_ADD) ? ST_UPD : ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          // ram_rdata holds the slot read in the previous cycle
          if ((req_q == REQ_FIND) && (ram_rdata == key_q)) begin
            rsp_q.found <= 1'b1;
          end
          state_q <= ST_RESP;
        end
        ST_NEXT_CLR: begin
          pend_q   <= 1'b0;
          lvalid_q <= 1'b0;
          state_q  <= ST_SCAN_RD;
        end
        ST_SCAN_RD: begin
          if (pos_in_range) begin
            state_q <= ST_SCAN_CHK;
          end else begin
            // pos is left at the size when the scan ran off the end
            rsp_q.iter_done <= 1'b1;
            state_q         <= ST_RESP;
          end
        end
        ST_SCAN_CHK: begin
          pos_q <= pos_q + PosW'(1);
          if (ram_rdata != '0) begin
            rsp_q.item_value <= ram_rdata;
            last_slot_q      <= pos_q[SlotW-1:0];
            lvalid_q         <= 1'b1;
            state_q          <= ST_RESP;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_rsp_q   <= rsp_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> tb/direct_mapped_hash_set_tb.sv
module direct_mapped_hash_set_tb;
  import dmhs_pkg::*;

  localparam int Slots = 256;
  localparam int Phases = 12;
  localparam int ReqsPerPhase = 160;

  // request codes with no operation behind them
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  localparam hs_rsp_t NoRsp  = '0;
  localparam hs_rsp_t EndRsp = '{found: 1'b0, item_value: '0, iter_done: 1'b1};

  typedef struct packed {
    logic [2:0]         op;
    logic [KeyBits-1:0] key;
    logic               typed;
    hs_rsp_t            rsp;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  hs_req_t            in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  hs_rsp_t            out_rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow of the set
  logic [KeyBits-1:0] tbl [Slots];
  int unsigned        walk_pos;
  int unsigned        walk_last;
  bit                 drop_pending;
  bit                 walk_has_item;
  logic [CfgBits-1:0] size_reg;

  hs_rsp_t            rsp_due [$];
  logic [KeyBits-1:0] seen_keys [$];
  int                 mismatches = 0;
  int                 reqs_sent = 0;
  bit                 idle_on = 1'b0;
  int                 stall_left = 0;

  // directed requests walk through collisions, the iterator and deferred removal
  dir_row_t dir_rows [25] = '{
    '{REQ_FIND,       32'd5,          1'b1, NoRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b1, EndRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b1, EndRsp},
    '{REQ_ADD,        32'd0,          1'b1, NoRsp},
    '{REQ_FIND,       32'd0,          1'b1, NoRsp},
    '{REQ_ADD,        32'hFFFF_FFFF,  1'b1, NoRsp},
    '{REQ_ADD,        32'd1,          1'b1, NoRsp},
    '{REQ_ADD,        32'd257,        1'b1, NoRsp},
    '{REQ_FIND,       32'd1,          1'b0, NoRsp},
    '{REQ_FIND,       32'd257,        1'b0, NoRsp},
    '{REQ_REMOVE,     32'd1,          1'b0, NoRsp},
    '{REQ_FIND,       32'hFFFF_FFFF,  1'b0, NoRsp},
    '{REQ_ITER_REM,   32'd0,          1'b1, NoRsp},
    '{REQ_ITER_START, 32'd0,          1'b1, NoRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b0, NoRsp},
    '{REQ_ITER_REM,   32'd0,          1'b1, NoRsp},
    '{REQ_ITER_REM,   32'd0,          1'b1, NoRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b0, NoRsp},
    '{REQ_ITER_REM,   32'd0,          1'b1, NoRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b0, NoRsp},
    '{REQ_ITER_NEXT,  32'd0,          1'b0, NoRsp},
    '{REQ_UNUSED_LO,  32'hFFFF_FFFF,  1'b1, NoRsp},
    '{REQ_UNUSED_HI,  32'd1,          1'b1, NoRsp},
    '{REQ_FIND,       32'd257,        1'b0, NoRsp},
    '{REQ_REMOVE,     32'd0,          1'b1, NoRsp}
  };

  logic [CfgBits-1:0] phase_sizes [Phases] = '{
    9'd1, 9'd0, 9'h1FF, 9'd2, 9'd17, 9'd256, 9'd255, 9'd3, 9'd300, 9'd64, 9'd100, 9'd256
  };

  direct_mapped_hash_set dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_size();
    if (size_reg == '0) return 1;
    if (size_reg > Slots) return Slots;
    return size_reg;
  endfunction

  // applies one request to the shadow set and returns the response it gives
  function automatic hs_rsp_t set_apply(hs_req_t r);
    hs_rsp_t     rsp;
    int unsigned sz;
    int unsigned s;
    int unsigned i;
    rsp = '0;
    sz = eff_size();
    s = r.key % sz;
    case (r.req_type)
      REQ_ADD: if (r.key != '0) tbl[s] = r.key;
      REQ_FIND: rsp.found = (r.key != '0) && (tbl[s] == r.key);
      REQ_REMOVE: if (r.key != '0 && tbl[s] == r.key) tbl[s] = '0;
      REQ_ITER_START: begin
        walk_pos = 0;
        drop_pending = 1'b0;
        walk_has_item = 1'b0;
      end
      REQ_ITER_NEXT: begin
        // deferred removal hits the last returned slot whatever it holds now
        if (drop_pending) begin
          tbl[walk_last % Slots] = '0;
          drop_pending = 1'b0;
          walk_has_item = 1'b0;
        end
        i = walk_pos;
        while (i < sz && tbl[i] == '0) i++;
        if (i < sz) begin
          rsp.item_value = tbl[i];
          walk_last = i;
          walk_has_item = 1'b1;
          walk_pos = i + 1;
        end else begin
          rsp.iter_done = 1'b1;
          if (walk_pos < sz) walk_pos = sz;
        end
      end
      REQ_ITER_REM: if (walk_has_item) drop_pending = 1'b1;
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic logic [KeyBits-1:0] pick_key();
    int unsigned sz;
    sz = eff_size();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2, 3: return $urandom_range(1, 3 * sz);
      4, 5, 6: begin
        if (seen_keys.size() != 0) return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        return $urandom();
      end
      7: begin
        // same slot as a stored key, different value
        if (seen_keys.size() != 0)
          return seen_keys[$urandom_range(0, seen_keys.size() - 1)] + sz * $urandom_range(1, 4);
        return $urandom();
      end
      8: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return sz * $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [KeyBits-1:0] key,
                          input bit typed, input hs_rsp_t want);
    hs_req_t r;
    hs_rsp_t rsp;
    int      gap;
    r.req_type = op;
    r.key = key;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    rsp = set_apply(r);
    rsp_due.push_back(typed ? want : rsp);
    if (op == REQ_ADD && key != '0) begin
      seen_keys.push_back(key);
      if (seen_keys.size() > 32) void'(seen_keys.pop_front());
    end
    reqs_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_size(input logic [CfgBits-1:0] v);
    logic [31:0] rd;
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {CFG_ACTIVE_SIZE, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_reg = v;
    // read back right away
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[CfgBits-1:0] !== v) begin
      $error("active_size: expected %0d, got %0d", v, rd[CfgBits-1:0]);
      mismatches++;
    end
  endtask

  task automatic run_random(input int n);
    int          target;
    int          walk;
    int unsigned sz;
    target = reqs_sent + n;
    while (reqs_sent < target) begin
      sz = eff_size();
      case ($urandom_range(0, 9))
        0, 1, 2: send_req(REQ_ADD, pick_key(), 1'b0, NoRsp);
        3, 4: send_req(REQ_FIND, pick_key(), 1'b0, NoRsp);
        5: send_req(REQ_REMOVE, pick_key(), 1'b0, NoRsp);
        6, 7: begin
          // a walk, sometimes past the end on small tables
          send_req(REQ_ITER_START, $urandom(), 1'b0, NoRsp);
          walk = (sz <= 20) ? $urandom_range(1, sz + 3) : $urandom_range(1, 12);
          repeat (walk) begin
            send_req(REQ_ITER_NEXT, $urandom(), 1'b0, NoRsp);
            if ($urandom_range(0, 3) == 0) send_req(REQ_ITER_REM, $urandom(), 1'b0, NoRsp);
            if ($urandom_range(0, 15) == 0) send_req(REQ_ITER_REM, $urandom(), 1'b0, NoRsp);
          end
        end
        8: send_req($urandom_range(0, 1) ? REQ_ITER_NEXT : REQ_ITER_REM, $urandom(), 1'b0,
                    NoRsp);
        default: send_req(3'($urandom_range(REQ_ADD, REQ_UNUSED_HI)), $urandom(), 1'b0, NoRsp);
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    hs_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_due.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        if (out_rsp_o.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_rsp_o.found);
          mismatches++;
        end
        if (out_rsp_o.item_value !== want.item_value) begin
          $error("item_value: expected %0h, got %0h", want.item_value, out_rsp_o.item_value);
          mismatches++;
        end
        if (out_rsp_o.iter_done !== want.iter_done) begin
          $error("iter_done: expected %0d, got %0d", want.iter_done, out_rsp_o.iter_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("direct_mapped_hash_set_tb failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (tbl[i]) tbl[i] = '0;
    walk_pos = 0;
    walk_last = 0;
    drop_pending = 1'b0;
    walk_has_item = 1'b0;
    size_reg = ActiveSizeRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    foreach (dir_rows[i]) send_req(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
                                   dir_rows[i].rsp);
    for (int p = 0; p < Phases; p++) begin
      write_size(phase_sizes[p]);
      // last phase runs flat out, others mostly with idling
      idle_on = (p != Phases - 1) && ($urandom_range(0, 3) != 0);
      run_random(ReqsPerPhase);
    end
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("direct_mapped_hash_set_tb passed");
    end else begin
      $display("direct_mapped_hash_set_tb failed");
    end
    $finish;
  end

endmodule
